### rtl/core/srtci_pkg.sv
package srtci_pkg;

	localparam int FIELD_W        = 16;
	localparam int INDEX_BITS_DEF = 16;
	localparam logic [FIELD_W-1:0] NODE_COUNT_RST = 16'd1;

endpackage

### rtl/core/sorted_rank_to_complete_tree_index_core.sv
// channel   dir  handshake                    payload
// item      in   start & !busy                rank
// result    out  result_valid (1-cycle beat)  tree_index, rank_out_of_range
// config    in   cfg_valid & cfg_ready        cfg_data (node_count)
//
// One rank per cycle, with one register stage per tree
// level, plus an entry stage and an output register.
// busy and cfg_ready are always low and high; the pipeline never stalls and
// the receiver cannot stall it.
// arst_n clears the valid chain and sets node_count to 1.
module sorted_rank_to_complete_tree_index_core #(
	parameter int INDEX_BITS = srtci_pkg::INDEX_BITS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	output logic                         busy,
	input  logic [srtci_pkg::FIELD_W-1:0] rank,
	output logic                         result_valid,
	output logic [srtci_pkg::FIELD_W-1:0] tree_index,
	output logic                         rank_out_of_range,
	input  logic                         cfg_valid,
	output logic                         cfg_ready,
	input  logic [srtci_pkg::FIELD_W-1:0] cfg_data
);
	import srtci_pkg::*;

	localparam int W  = INDEX_BITS;
	localparam int HW = $clog2(INDEX_BITS + 1);

	logic [W-1:0]  node_count_q, cfg_nc;
	logic [HW-1:0] height_q, cfg_h;
	logic [W-1:0]  rank_w;
	logic          accept;

	logic          lvl_valid_s [0:W];
	logic          lvl_done_s  [0:W];
	logic [W-1:0]  lvl_rank_s  [0:W];
	logic [W-1:0]  lvl_lo_s    [0:W];
	logic [W-1:0]  lvl_n_s     [0:W];
	logic [HW-1:0] lvl_h_s     [0:W];
	logic [W-1:0]  lvl_idx_s   [0:W];
	logic          oor_s       [0:W];

	logic          out_valid_q, out_oor_q;
	logic [W-1:0]  out_idx_q;

	assign busy      = 1'b0;
	assign cfg_ready = 1'b1;
	assign accept    = start && !busy;
	assign rank_w    = W'(32'(rank));
	assign cfg_nc    = W'(32'(cfg_data));

	// tree height = bit length of node_count
	always_comb begin
		cfg_h = '0;
		for (int i = 0; i < W; i++) begin
			if (cfg_nc[i]) cfg_h = HW'(i + 1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			node_count_q <= W'(32'(NODE_COUNT_RST));
			height_q     <= HW'(1);
		end else if (cfg_valid && cfg_ready) begin
			node_count_q <= cfg_nc;
			height_q     <= cfg_h;
		end
	end

	// entry stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lvl_valid_s[0] <= 1'b0;
		end else begin
			lvl_valid_s[0] <= accept;
		end
	end

	always_ff @(posedge clk) begin
		lvl_rank_s[0] <= rank_w;
		lvl_done_s[0] <= rank_w >= node_count_q;
		oor_s[0]      <= rank_w >= node_count_q;
		lvl_lo_s[0]   <= '0;
		lvl_n_s[0]    <= node_count_q;
		lvl_h_s[0]    <= height_q;
		lvl_idx_s[0]  <= '0;
	end

	for (genvar k = 0; k < W; k++) begin : g_lvl
		srtci_level #(
			.W (W),
			.HW(HW)
		) u_level (
			.clk      (clk),
			.arst_n   (arst_n),
			.in_valid (lvl_valid_s[k]),
			.in_done  (lvl_done_s[k]),
			.in_rank  (lvl_rank_s[k]),
			.in_lo    (lvl_lo_s[k]),
			.in_n     (lvl_n_s[k]),
			.in_h     (lvl_h_s[k]),
			.in_idx   (lvl_idx_s[k]),
			.out_valid(lvl_valid_s[k+1]),
			.out_done (lvl_done_s[k+1]),
			.out_rank (lvl_rank_s[k+1]),
			.out_lo   (lvl_lo_s[k+1]),
			.out_n    (lvl_n_s[k+1]),
			.out_h    (lvl_h_s[k+1]),
			.out_idx  (lvl_idx_s[k+1])
		);

		always_ff @(posedge clk) begin
			oor_s[k+1] <= oor_s[k];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else begin
			out_valid_q <= lvl_valid_s[W];
		end
	end

	always_ff @(posedge clk) begin
		out_oor_q <= oor_s[W];
		out_idx_q <= oor_s[W] ? '0 : lvl_idx_s[W];
	end

	assign result_valid      = out_valid_q;
	assign rank_out_of_range = out_oor_q;
	assign tree_index        = FIELD_W'(32'(out_idx_q));

`ifndef NO_ASSERTIONS
	a_oor_zero: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && rank_out_of_range |-> tree_index == '0)
		else $error("out-of-range beat with nonzero index");

	a_found_by_last_level: assert property (@(posedge clk) disable iff (!arst_n)
		lvl_valid_s[W] |-> lvl_done_s[W])
		else $error("rank not located within the level pipeline");

	a_height_matches: assert property (@(posedge clk) disable iff (!arst_n)
		node_count_q != '0 |-> height_q != '0 && (node_count_q >> (height_q - HW'(1))) == W'(1))
		else $error("tree height does not match node_count");
`endif

endmodule

### rtl/core/srtci_level.sv
module srtci_level #(
	parameter int W  = srtci_pkg::INDEX_BITS_DEF,
	parameter int HW = $clog2(srtci_pkg::INDEX_BITS_DEF + 1)
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	input  logic          in_done,
	input  logic [W-1:0]  in_rank,
	input  logic [W-1:0]  in_lo,
	input  logic [W-1:0]  in_n,
	input  logic [HW-1:0] in_h,
	input  logic [W-1:0]  in_idx,
	output logic          out_valid,
	output logic          out_done,
	output logic [W-1:0]  out_rank,
	output logic [W-1:0]  out_lo,
	output logic [W-1:0]  out_n,
	output logic [HW-1:0] out_h,
	output logic [W-1:0]  out_idx
);
	import srtci_pkg::*;

	logic [W:0]   half, quad, left_ext;
	logic [W+1:0] lhs, rhs;
	logic         short_last;
	logic [W-1:0] left, root;
	logic         hit, go_left;

	// root rank of the current subtree
	always_comb begin
		half       = (in_h == '0) ? '0 : ((W+1)'(1) << (in_h - HW'(1)));
		quad       = half >> 1;
		lhs        = (W+2)'(in_n) + (W+2)'(1);
		rhs        = (W+2)'(half) + (W+2)'(quad);
		short_last = lhs < rhs;
		left_ext   = short_last ? ((W+1)'(in_n) + quad - half) : (half - (W+1)'(1));
		left       = (in_h == '0) ? '0 : W'(left_ext);
		root       = in_lo + left;
		hit        = in_rank == root;
		go_left    = in_rank < root;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else begin
			out_valid <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		out_rank <= in_rank;
		if (in_done || hit) begin
			out_done <= 1'b1;
			out_lo   <= in_lo;
			out_n    <= in_n;
			out_h    <= in_h;
			out_idx  <= in_idx;
		end else if (go_left) begin
			out_done <= 1'b0;
			out_lo   <= in_lo;
			out_n    <= left;
			out_h    <= in_h - HW'(1);
			out_idx  <= W'({in_idx, 1'b1});
		end else begin
			out_done <= 1'b0;
			out_lo   <= root + W'(1);
			out_n    <= in_n - left - W'(1);
			out_h    <= in_h - (short_last ? HW'(2) : HW'(1));
			out_idx  <= W'({in_idx + W'(1), 1'b0});
		end
	end

endmodule
